// ===== rtl/sha1s_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1s_pkg: shared types and constants
// SHA-1 initial hash values, round constants and the command/status bundle
// that joins the controller to the datapath.
// ----------------------------------------------------------------------------
package sha1s_pkg;

    typedef logic [31:0] t_word;
    typedef logic [6:0]  t_round;

    localparam t_word H_INIT [0:4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam t_word K_00_19 = 32'h5A827999;
    localparam t_word K_20_39 = 32'h6ED9EBA1;
    localparam t_word K_40_59 = 32'h8F1BBCDC;
    localparam t_word K_60_79 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam t_round     ROUND_LAST = 7'd79;
    localparam logic [2:0] WORD_LAST  = 3'd4;
    localparam logic [2:0] BYTES_MAX  = 3'd4;
    // first buffer position at which the length no longer fits in the block
    localparam logic [5:0] PAD_TWO_POS = 6'd56;

    typedef struct packed {
        logic       load_item;  // merge the accepted beat into the block
        logic       round;      // one compression round
        logic       fin;        // add working vars into chaining state
        logic       spill;      // write carried bytes into word 0
        logic       pad;        // 0x80, zero fill, length if it fits
        logic       pad2;       // zero block with length only
        logic       reinit;     // back to initial state after digest
        t_round     rnd;
        logic [2:0] out_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic full;     // beat at the input completes the block
        logic pad_two;  // padding needs a second block
    } t_dp_sts;

endpackage

// ===== rtl/sha1s_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1s_in_if / sha1s_out_if: stream channels
// Valid/ready channels for message beats and digest words.
// ----------------------------------------------------------------------------
interface sha1s_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;

    modport source (output valid, output data_word, output byte_count,
                    output last, input ready);
    modport sink   (input valid, input data_word, input byte_count,
                    input last, output ready);
endinterface

interface sha1s_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

// ===== rtl/sha1s_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1s_dp: SHA-1 datapath
// Block buffer doubling as the message schedule window, byte-lane merge,
// padding, one-round-per-cycle compression and the chaining state.
// ----------------------------------------------------------------------------
module sha1s_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha1s_pkg::t_dp_cmd i_cmd,
    input  logic [31:0]       i_data_word,
    input  logic [2:0]        i_byte_count,
    output sha1s_pkg::t_dp_sts o_sts,
    output logic [31:0]       o_digest_word
);
    import sha1s_pkg::*;

    function automatic t_word merge(t_word o, t_word nw, logic [3:0] be);
        t_word r;
        r = o;
        for (int j = 0; j < 4; j++) begin
            if (be[j]) begin
                r[31-8*j -: 8] = nw[31-8*j -: 8];
            end
        end
        return r;
    endfunction

    t_word       r_win [0:15];
    t_word       n_win [0:15];
    t_word       r_h   [0:4];
    t_word       n_h   [0:4];
    t_word       r_v   [0:4];   // a, b, c, d, e
    t_word       n_v   [0:4];
    logic [5:0]  r_buf, n_buf;
    logic [60:0] r_msg, n_msg;
    t_word       r_spill_data, n_spill_data;
    logic [3:0]  r_spill_en, n_spill_en;

    logic [2:0]  cnt;
    logic [1:0]  lane;
    logic [3:0]  widx;
    logic [6:0]  sum;
    logic [63:0] sh;
    logic [7:0]  en;
    logic [63:0] len_bits;
    t_word       f, k, t, wnew;

    assign cnt      = (i_byte_count > BYTES_MAX) ? BYTES_MAX : i_byte_count;
    assign lane     = r_buf[1:0];
    assign widx     = r_buf[5:2];
    assign sum      = {1'b0, r_buf} + {4'b0, cnt};
    assign sh       = {i_data_word, 32'h0} >> {lane, 3'b000};
    assign len_bits = {r_msg, 3'b000};

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            en[j] = (4'(j) >= {2'b00, lane}) && (4'(j) < ({2'b00, lane} + {1'b0, cnt}));
        end
    end

    // round function
    always_comb begin
        if (i_cmd.rnd < 7'd20) begin
            f = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            k = K_00_19;
        end else if (i_cmd.rnd < 7'd40) begin
            f = r_v[1] ^ r_v[2] ^ r_v[3];
            k = K_20_39;
        end else if (i_cmd.rnd < 7'd60) begin
            f = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            k = K_40_59;
        end else begin
            f = r_v[1] ^ r_v[2] ^ r_v[3];
            k = K_60_79;
        end
        t    = {r_v[0][26:0], r_v[0][31:27]} + f + r_v[4] + k + r_win[0];
        wnew = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
        wnew = {wnew[30:0], wnew[31]};
    end

    always_comb begin
        n_win        = r_win;
        n_h          = r_h;
        n_v          = r_v;
        n_buf        = r_buf;
        n_msg        = r_msg;
        n_spill_data = r_spill_data;
        n_spill_en   = r_spill_en;

        if (i_cmd.load_item) begin
            n_win[widx] = merge(r_win[widx], sh[63:32], en[3:0]);
            if (widx != 4'hF) begin
                n_win[widx + 4'd1] = merge(r_win[widx + 4'd1], sh[31:0], en[7:4]);
            end
            // bytes that run past the block end land in word 0 later
            n_spill_data = sh[31:0];
            n_spill_en   = en[7:4];
            n_buf        = sum[5:0];
            n_msg        = r_msg + 61'(cnt);
        end else if (i_cmd.round) begin
            for (int w = 0; w < 15; w++) begin
                n_win[w] = r_win[w+1];
            end
            n_win[15] = wnew;
            n_v[0] = t;
            n_v[1] = r_v[0];
            n_v[2] = {r_v[1][1:0], r_v[1][31:2]};
            n_v[3] = r_v[2];
            n_v[4] = r_v[3];
        end else if (i_cmd.fin) begin
            for (int i = 0; i < 5; i++) begin
                n_h[i] = r_h[i] + r_v[i];
                n_v[i] = r_h[i] + r_v[i];
            end
        end else if (i_cmd.spill) begin
            n_win[0] = merge(r_win[0], r_spill_data, r_spill_en);
        end else if (i_cmd.pad) begin
            for (int w = 0; w < 16; w++) begin
                if (4'(w) == widx) begin
                    for (int j = 0; j < 4; j++) begin
                        if (2'(j) == lane) begin
                            n_win[w][31-8*j -: 8] = PAD_BYTE;
                        end else if (2'(j) > lane) begin
                            n_win[w][31-8*j -: 8] = 8'h00;
                        end
                    end
                end else if (4'(w) > widx) begin
                    n_win[w] = '0;
                end
            end
            if (!o_sts.pad_two) begin
                n_win[14] = len_bits[63:32];
                n_win[15] = len_bits[31:0];
            end
        end else if (i_cmd.pad2) begin
            for (int w = 0; w < 14; w++) begin
                n_win[w] = '0;
            end
            n_win[14] = len_bits[63:32];
            n_win[15] = len_bits[31:0];
        end else if (i_cmd.reinit) begin
            n_h   = H_INIT;
            n_v   = H_INIT;
            n_buf = '0;
            n_msg = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h   <= H_INIT;
            r_v   <= H_INIT;
            r_buf <= '0;
            r_msg <= '0;
        end else begin
            r_h   <= n_h;
            r_v   <= n_v;
            r_buf <= n_buf;
            r_msg <= n_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win        <= n_win;
        r_spill_data <= n_spill_data;
        r_spill_en   <= n_spill_en;
    end

    assign o_sts.full     = sum[6];
    assign o_sts.pad_two  = (r_buf >= PAD_TWO_POS);
    assign o_digest_word  = r_h[i_cmd.out_idx];

endmodule

// ===== rtl/sha1s_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1s_ctrl: SHA-1 sequencer
// Steps the datapath through merge, compression, padding and digest output.
// ----------------------------------------------------------------------------
module sha1s_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_out_word_index,
    output logic               o_out_last_word,
    input  sha1s_pkg::t_dp_sts i_sts,
    output sha1s_pkg::t_dp_cmd o_cmd
);
    import sha1s_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_COMP  = 3'd1;
    localparam logic [2:0] ST_FIN   = 3'd2;
    localparam logic [2:0] ST_SPILL = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_PAD2  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    // where to go once a block is folded into the chaining state
    localparam logic [1:0] AF_SPILL = 2'd0;
    localparam logic [1:0] AF_PAD2  = 2'd1;
    localparam logic [1:0] AF_EMIT  = 2'd2;

    logic [2:0] r_state, n_state;
    logic [1:0] r_after, n_after;
    logic       r_last,  n_last;
    t_round     r_rnd,   n_rnd;
    logic [2:0] r_idx,   n_idx;
    logic       in_acc, out_acc;

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_out_valid      = (r_state == ST_EMIT);
    assign o_out_word_index = r_idx;
    assign o_out_last_word  = (r_idx == WORD_LAST);
    assign in_acc           = o_in_ready && i_in_valid;
    assign out_acc          = o_out_valid && i_out_ready;

    assign o_cmd.load_item = in_acc;
    assign o_cmd.round     = (r_state == ST_COMP);
    assign o_cmd.fin       = (r_state == ST_FIN);
    assign o_cmd.spill     = (r_state == ST_SPILL);
    assign o_cmd.pad       = (r_state == ST_PAD);
    assign o_cmd.pad2      = (r_state == ST_PAD2);
    assign o_cmd.reinit    = out_acc && o_out_last_word;
    assign o_cmd.rnd       = r_rnd;
    assign o_cmd.out_idx   = r_idx;

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_last  = r_last;
        n_rnd   = r_rnd;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_last = i_in_last;
                    if (i_sts.full) begin
                        n_state = ST_COMP;
                        n_after = AF_SPILL;
                    end else if (i_in_last) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_COMP: begin
                if (r_rnd == ROUND_LAST) begin
                    n_rnd   = '0;
                    n_state = ST_FIN;
                end else begin
                    n_rnd = r_rnd + 7'd1;
                end
            end
            ST_FIN: begin
                unique case (r_after)
                    AF_SPILL: n_state = ST_SPILL;
                    AF_PAD2:  n_state = ST_PAD2;
                    AF_EMIT: begin
                        n_state = ST_EMIT;
                        n_idx   = '0;
                    end
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_SPILL: begin
                n_state = r_last ? ST_PAD : ST_IDLE;
            end
            ST_PAD: begin
                n_state = ST_COMP;
                n_after = i_sts.pad_two ? AF_PAD2 : AF_EMIT;
            end
            ST_PAD2: begin
                n_state = ST_COMP;
                n_after = AF_EMIT;
            end
            ST_EMIT: begin
                if (out_acc) begin
                    if (o_out_last_word) begin
                        n_state = ST_IDLE;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_after <= AF_SPILL;
            r_last  <= 1'b0;
            r_rnd   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_last  <= n_last;
            r_rnd   <= n_rnd;
            r_idx   <= n_idx;
        end
    end

endmodule

// ===== rtl/sha1_stream_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_stream_hash: streaming SHA-1 hasher
// Byte-granular message intake, 80-round compression, padding and a five
// beat digest per message.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat payload                      | handshake
//  --------+-----+-----------------------------------+-------------
//  i_in    | in  | data_word, byte_count, last       | valid/ready
//  o_out   | out | digest_word, word_index, last_word| valid/ready
//
//  Flow: a beat that leaves the 64-byte block open is only merged; one that
//  fills it also runs 80 rounds, a fold into the chaining state and a spill
//  of carried bytes. A last beat adds pad, 80 rounds and fold, again for a
//  second block when the length needs one, then 5 digest beats.
//  Reset: synchronous, active low; chaining state back to the initial values.
//  Stalls: input is taken only while idle; digest beats hold under backpressure.
//
module sha1_stream_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha1s_in_if.sink    i_in,
    sha1s_out_if.source o_out
);
    import sha1s_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: owns both handshakes and the round counter
    sha1s_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in.valid),
        .i_in_last        (i_in.last),
        .o_in_ready       (i_in.ready),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_out_word_index (o_out.word_index),
        .o_out_last_word  (o_out.last_word),
        .i_sts            (sts),
        .o_cmd            (cmd)
    );

    // datapath: block buffer / schedule window, working vars, chaining state
    sha1s_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_word   (i_in.data_word),
        .i_byte_count  (i_in.byte_count),
        .o_sts         (sts),
        .o_digest_word (o_out.digest_word)
    );

    // intake and digest output never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while digest pending");

    // digest words come out in order with no gap
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last_word) |=>
        (o_out.valid && (o_out.word_index == 3'($past(o_out.word_index) + 3'd1))))
        else $error("digest word index skipped");

    // after the final digest beat the hasher is ready for a new message
    a_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_word) |=> i_in.ready)
        else $error("not idle after digest");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the streaming SHA-1 hasher
// Feeds whole messages in 32-bit beats (short and oversized byte counts
// mixed in) and checks every digest word against a bit-exact SHA-1 model
// kept in the bench. Both channels idle at random, and one long
// output hold-off backs the hasher up into its input.
// ----------------------------------------------------------------------------
module tb_top;
    import sha1s_pkg::*;

    // Beat types for the two channels
    typedef struct {
        logic [31:0] data;
        logic [2:0]  cnt;
        logic        last;
    } t_msg_beat;

    typedef struct {
        t_word      digest;
        logic [2:0] idx;
        logic       last;
    } t_digest_beat;

    localparam int HOLD_CYCLES = 400;  // long output hold-off
    localparam int DRAIN_WAIT  = 200;  // extra wait after the last digest word

    logic i_clk;
    logic i_rst_n;

    sha1s_in_if  in_ch ();
    sha1s_out_if out_ch ();

    sha1_stream_hash DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Stimulus and scoreboard storage
    t_msg_beat    beat_q[$];     // beats not yet offered
    t_msg_beat    cur_beat;      // beat currently on the input channel
    t_digest_beat digest_q[$];   // digest words still to come
    int           beats_queued;
    int           err_cnt;

    // Idle odds per channel, set per phase
    int tx_idle_pct;
    int rx_idle_pct;

    // Output hold-off control
    logic hold_go;
    logic hold_done;
    int   hold_left;

    // Bench copy of the hasher state
    t_word       hash_state [5];
    logic [7:0]  blk_bytes  [64];
    int unsigned blk_fill;
    logic [60:0] msg_len;

    // ------------------------------------------------------------------------
    // SHA-1 predictor
    // ------------------------------------------------------------------------
    function automatic t_word rotl(t_word v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // One 80-round compression of blk_bytes into hash_state
    function automatic void sha1_compress();
        t_word w [80];
        t_word a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        end
        for (int i = 16; i < 80; i++) begin
            w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = K_00_19;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = K_20_39;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_40_59;
            end else begin
                f = b ^ c ^ d;
                k = K_60_79;
            end
            t = rotl(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    function automatic void hash_reinit();
        for (int i = 0; i < 5; i++) hash_state[i] = H_INIT[i];
        blk_fill = 0;
        msg_len  = '0;
    endfunction

    // Absorb one accepted beat; a last beat pads and yields five digest words
    function automatic void hash_beat(t_msg_beat bt);
        int unsigned n;
        int unsigned pos;
        logic [63:0] bit_len;
        t_digest_beat db;
        n = 32'((bt.cnt > BYTES_MAX) ? BYTES_MAX : bt.cnt);  // 5..7 act as 4
        for (int i = 0; i < n; i++) begin
            blk_bytes[blk_fill] = bt.data[31 - 8*i -: 8];
            blk_fill++;
            if (blk_fill == 64) begin
                sha1_compress();
                blk_fill = 0;
            end
        end
        msg_len = msg_len + 61'(n);
        if (!bt.last) return;

        pos = blk_fill;
        blk_bytes[pos] = PAD_BYTE;
        pos++;
        // length field no longer fits: zero-fill and flush a first block
        if (pos > PAD_TWO_POS) begin
            while (pos < 64) begin
                blk_bytes[pos] = 8'h00;
                pos++;
            end
            sha1_compress();
            pos = 0;
        end
        while (pos < PAD_TWO_POS) begin
            blk_bytes[pos] = 8'h00;
            pos++;
        end
        bit_len = {msg_len, 3'b000};
        for (int i = 0; i < 8; i++) blk_bytes[56 + i] = bit_len[63 - 8*i -: 8];
        sha1_compress();

        for (int i = 0; i < 5; i++) begin
            db.digest = hash_state[i];
            db.idx    = 3'(i);
            db.last   = (3'(i) == WORD_LAST);
            digest_q.insert(digest_q.size(), db);
        end
        hash_reinit();
    endfunction

    // ------------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input driver: offers queued beats, predicts on each accepted beat
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) hash_beat(cur_beat);
            // slot is free when nothing is offered or the offer just went in
            if (!in_ch.valid || in_ch.ready) begin
                if (beat_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cur_beat = beat_q.pop_front();
                    in_ch.data_word  <= cur_beat.data;
                    in_ch.byte_count <= cur_beat.cnt;
                    in_ch.last       <= cur_beat.last;
                    in_ch.valid      <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long output hold-off, started once by the stimulus
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: random ready, in-order compare against digest_q
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        t_digest_beat want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
            if (out_ch.valid && out_ch.ready) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected digest beat: expected none, actual %h idx %0d",
                             $realtime, out_ch.digest_word, out_ch.word_index);
                    err_cnt++;
                end else begin
                    want = digest_q.pop_front();
                    if (out_ch.digest_word !== want.digest) begin
                        $display("%0t: digest_word: expected %h actual %h",
                                 $realtime, want.digest, out_ch.digest_word);
                        err_cnt++;
                    end
                    if (out_ch.word_index !== want.idx) begin
                        $display("%0t: word_index: expected %0d actual %0d",
                                 $realtime, want.idx, out_ch.word_index);
                        err_cnt++;
                    end
                    if (out_ch.last_word !== want.last) begin
                        $display("%0t: last_word: expected %b actual %b",
                                 $realtime, want.last, out_ch.last_word);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic add_beat(logic [31:0] data, logic [2:0] cnt, logic last);
        t_msg_beat bt;
        bt.data = data;
        bt.cnt  = cnt;
        bt.last = last;
        beat_q.insert(beat_q.size(), bt);
        beats_queued++;
    endtask

    // One message of n_beats beats; mostly full words, some short beats
    // mid-message so later words land unaligned
    task automatic queue_message(int n_beats);
        for (int i = 1; i < n_beats; i++) begin
            if ($urandom_range(99) < 15) add_beat($urandom, 3'($urandom_range(0, 7)), 1'b0);
            else                         add_beat($urandom, 3'd4, 1'b0);
        end
        add_beat($urandom, 3'($urandom_range(0, 7)), 1'b1);
    endtask

    // Random messages; a quarter sized to land near the block end so the
    // two-block padding path gets hit; the final message is cut to fit
    task automatic random_traffic(int n_items);
        int stop_at;
        int n_beats;
        stop_at = beats_queued + n_items;
        while (beats_queued < stop_at) begin
            if ($urandom_range(3) == 0) n_beats = int'($urandom_range(14, 17));
            else                        n_beats = int'($urandom_range(1, 12));
            if (n_beats > stop_at - beats_queued) n_beats = stop_at - beats_queued;
            queue_message(n_beats);
        end
    endtask

    task automatic wait_input_drained();
        while (beat_q.size() != 0 || in_ch.valid) @(posedge i_clk);
    endtask

    initial begin
        hold_go          = 1'b0;
        tx_idle_pct      = 29;
        rx_idle_pct      = 58;
        beats_queued     = 0;
        err_cnt          = 0;
        for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
        hash_reinit();

        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message, "abc"
        add_beat(32'h0000_0000, 3'd0, 1'b1);
        add_beat(32'h6162_6300, 3'd3, 1'b1);
        // zero-byte beat, oversized count, short beat, oversized last
        add_beat(32'hFFFF_FFFF, 3'd0, 1'b0);
        add_beat(32'hFFFF_FFFF, 3'd7, 1'b0);
        add_beat(32'h0000_0000, 3'd2, 1'b0);
        add_beat(32'h1234_5678, 3'd5, 1'b1);
        // 56-byte message: length spills into a second block
        for (int i = 0; i < 13; i++) add_beat(i[0] ? 32'hFFFF_FFFF : 32'h0000_0000, 3'd4, 1'b0);
        add_beat(32'hFFFF_FFFF, 3'd4, 1'b1);
        // single beat, count 6, all ones
        add_beat(32'hFFFF_FFFF, 3'd6, 1'b1);

        // Phase 1: sender idles less than receiver
        random_traffic(26);
        wait_input_drained();

        // Phase 2: swapped
        tx_idle_pct <= 58;
        rx_idle_pct <= 29;
        random_traffic(26);
        wait_input_drained();

        // Phase 3: no idling, long output stall up front backs up the input
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        hold_go     <= 1'b1;
        random_traffic(27);
        wait_input_drained();

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (err_cnt == 0 && digest_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
